/* sv/banked_memory_map_decoder_unit_assert.svh */
// Assertion macros for the banked memory map decoder unit
`ifndef BANKED_MEMORY_MAP_DECODER_UNIT_ASSERT_SVH
`define BANKED_MEMORY_MAP_DECODER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is high
`define BMMD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bmmd assertion failed");

// Next-cycle implication, disabled while reset is high
`define BMMD_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bmmd assertion failed");

`else

`define BMMD_ASSERT_IMP(label, clk, rst, ante, cons)
`define BMMD_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

/* sv/bmmd_pkg.sv */
// Shared types and constants for the banked memory map decoder
`timescale 1ns / 1ps

package bmmd_pkg;

   // Region sizes and derived offset bit counts
   localparam int ROM_BANK_BYTES  = 16384;
   localparam int VRAM_BANK_BYTES = 8192;
   localparam int WRAM_BANK_BYTES = 4096;
   localparam int ROM_BANK_BITS   = $clog2(ROM_BANK_BYTES);
   localparam int VRAM_BANK_BITS  = $clog2(VRAM_BANK_BYTES);
   localparam int WRAM_BANK_BITS  = $clog2(WRAM_BANK_BYTES);

   // Field widths
   localparam int ADDR_W   = 16;
   localparam int DATA_W   = 8;
   localparam int TARGET_W = 4;
   localparam int OFFSET_W = 21;

   // Target region codes
   localparam logic [TARGET_W-1:0] TGT_BOOT      = 4'd0;
   localparam logic [TARGET_W-1:0] TGT_ROM       = 4'd1;
   localparam logic [TARGET_W-1:0] TGT_VRAM      = 4'd2;
   localparam logic [TARGET_W-1:0] TGT_EXT_RAM   = 4'd3;
   localparam logic [TARGET_W-1:0] TGT_WRAM      = 4'd4;
   localparam logic [TARGET_W-1:0] TGT_OAM       = 4'd5;
   localparam logic [TARGET_W-1:0] TGT_IO        = 4'd6;
   localparam logic [TARGET_W-1:0] TGT_HRAM      = 4'd7;
   localparam logic [TARGET_W-1:0] TGT_IE        = 4'd8;
   localparam logic [TARGET_W-1:0] TGT_BANK_CTRL = 4'd9;

   // Access kinds
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Address map boundaries
   localparam logic [ADDR_W-1:0] BOOT_END        = 16'h0100;
   localparam logic [ADDR_W-1:0] ROM_SWITCH_BASE = 16'h4000;
   localparam logic [ADDR_W-1:0] VRAM_BASE       = 16'h8000;
   localparam logic [ADDR_W-1:0] EXT_RAM_BASE    = 16'hA000;
   localparam logic [ADDR_W-1:0] WRAM_BASE       = 16'hC000;
   localparam logic [ADDR_W-1:0] ECHO_BASE       = 16'hE000;
   localparam logic [ADDR_W-1:0] OAM_BASE        = 16'hFE00;
   localparam logic [ADDR_W-1:0] IO_BASE         = 16'hFF00;
   localparam logic [ADDR_W-1:0] HRAM_BASE       = 16'hFF80;
   localparam logic [ADDR_W-1:0] IE_ADDR         = 16'hFFFF;
   localparam logic [ADDR_W-1:0] VBK_ADDR        = 16'hFF4F;
   localparam logic [ADDR_W-1:0] SVBK_ADDR       = 16'hFF70;

   // Request word
   typedef struct packed {
      logic              opcode;
      logic [ADDR_W-1:0] address;
      logic [DATA_W-1:0] write_data;
   } req_word_type;

   // Response word
   typedef struct packed {
      logic [TARGET_W-1:0] target;
      logic [OFFSET_W-1:0] offset;
      logic                write_strobe;
      logic [DATA_W-1:0]   read_value;
   } rsp_word_type;

   // Bank controller and banking register state
   typedef struct packed {
      logic [6:0]        rom_bank;
      logic              ram_enabled;
      logic [1:0]        ram_bank;
      logic              rom_banking_mode;
      logic              video_bank;
      logic [2:0]        work_bank;
      logic [DATA_W-1:0] irq_enable_reg;
   } bank_state_type;

endpackage

/* sv/bmmd_bank_regs.sv */
// Bank controller, banking and interrupt-enable registers
`timescale 1ns / 1ps

module bmmd_bank_regs (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    update,
   input  bmmd_pkg::bank_state_type state_in,
   output bmmd_pkg::bank_state_type state
);
   import bmmd_pkg::*;

   bank_state_type state_ff;

   // Load the next state as each word leaves decode
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.rom_bank         <= 7'd1;
         state_ff.ram_enabled      <= 1'b0;
         state_ff.ram_bank         <= 2'd0;
         state_ff.rom_banking_mode <= 1'b1;
         state_ff.video_bank       <= 1'b0;
         state_ff.work_bank        <= 3'd1;
         state_ff.irq_enable_reg   <= '0;
      end else if (update) begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule

/* sv/bmmd_decode.sv */
// Address decode, offset generation and register update logic
`timescale 1ns / 1ps

module bmmd_decode (
   input  bmmd_pkg::req_word_type   req,
   input  bmmd_pkg::bank_state_type state,
   input  logic                     boot_overlay,
   output bmmd_pkg::rsp_word_type   rsp,
   output bmmd_pkg::bank_state_type state_next
);
   import bmmd_pkg::*;

   // Bank control write areas, picked by address bits 14:13
   localparam logic [1:0] BCTL_RAM_ENABLE = 2'd0;
   localparam logic [1:0] BCTL_ROM_LOW    = 2'd1;
   localparam logic [1:0] BCTL_UPPER      = 2'd2;
   localparam logic [1:0] BCTL_MODE       = 2'd3;

   logic [ADDR_W-1:0]   addr;
   logic [DATA_W-1:0]   data;
   logic                wr;
   logic [4:0]          rom_low;
   logic [6:0]          rom_sel;
   logic [2:0]          work_sel;
   logic [OFFSET_W-1:0] rom_offset;
   logic [OFFSET_W-1:0] vram_offset;
   logic [OFFSET_W-1:0] wram_offset;

   assign addr = req.address;
   assign data = req.write_data;
   assign wr   = (req.opcode == OP_WRITE);

   // Bank selects; zero in the low ROM field and in the WRAM bank act as one
   assign rom_low  = (data[4:0] == 5'd0) ? 5'd1 : data[4:0];
   assign rom_sel  = state.rom_banking_mode ? state.rom_bank : {2'b00, state.rom_bank[4:0]};
   assign work_sel = (state.work_bank == 3'd0) ? 3'd1 : state.work_bank;

   // Physical offsets for the banked regions
   assign rom_offset  = (OFFSET_W'(rom_sel) << ROM_BANK_BITS)
                      | OFFSET_W'(addr[ROM_BANK_BITS-1:0]);
   assign vram_offset = (OFFSET_W'(state.video_bank) << VRAM_BANK_BITS)
                      | OFFSET_W'(addr[VRAM_BANK_BITS-1:0]);
   // Echo area maps onto WRAM with the same bit 12, so one form serves both
   assign wram_offset = addr[WRAM_BANK_BITS] ?
                        ((OFFSET_W'(work_sel) << WRAM_BANK_BITS)
                         | OFFSET_W'(addr[WRAM_BANK_BITS-1:0])) :
                        OFFSET_W'(addr[WRAM_BANK_BITS-1:0]);

   // Decode the region and work out the register updates
   always_comb begin
      rsp        = '0;
      state_next = state;
      if (addr < VRAM_BASE) begin
         if (wr) begin
            rsp.target = TGT_BANK_CTRL;
            rsp.offset = OFFSET_W'(addr);
            case (addr[14:13])
               BCTL_RAM_ENABLE: state_next.ram_enabled = (data[3:0] == 4'hA);
               BCTL_ROM_LOW:    state_next.rom_bank = {state.rom_bank[6:5], rom_low};
               BCTL_UPPER: begin
                  if (state.rom_banking_mode) begin
                     state_next.rom_bank = {data[1:0], state.rom_bank[4:0]};
                  end else begin
                     state_next.ram_bank = data[1:0];
                  end
               end
               BCTL_MODE:       state_next.rom_banking_mode = ~data[0];
               default:         state_next = state;
            endcase
         end else if (addr < BOOT_END && boot_overlay) begin
            rsp.target = TGT_BOOT;
            rsp.offset = OFFSET_W'(addr);
         end else if (addr < ROM_SWITCH_BASE) begin
            rsp.target = TGT_ROM;
            rsp.offset = OFFSET_W'(addr);
         end else begin
            rsp.target = TGT_ROM;
            rsp.offset = rom_offset;
         end
      end else if (addr < EXT_RAM_BASE) begin
         rsp.target       = TGT_VRAM;
         rsp.offset       = vram_offset;
         rsp.write_strobe = wr;
      end else if (addr < WRAM_BASE) begin
         rsp.target = TGT_EXT_RAM;
      end else if (addr < OAM_BASE) begin
         // Plain WRAM and its echo
         rsp.target       = TGT_WRAM;
         rsp.offset       = wram_offset;
         rsp.write_strobe = wr;
      end else if (addr < IO_BASE) begin
         rsp.target       = TGT_OAM;
         rsp.offset       = OFFSET_W'(addr[7:0]);
         rsp.write_strobe = wr;
      end else if (addr < HRAM_BASE) begin
         rsp.target       = TGT_IO;
         rsp.offset       = OFFSET_W'(addr[6:0]);
         rsp.write_strobe = wr;
         if (wr && addr == VBK_ADDR) begin
            state_next.video_bank = data[0];
         end
         if (wr && addr == SVBK_ADDR) begin
            state_next.work_bank = data[2:0];
         end
      end else if (addr < IE_ADDR) begin
         rsp.target       = TGT_HRAM;
         rsp.offset       = OFFSET_W'(addr[6:0]);
         rsp.write_strobe = wr;
      end else begin
         rsp.target       = TGT_IE;
         rsp.write_strobe = wr;
         if (wr) begin
            state_next.irq_enable_reg = data;
         end else begin
            rsp.read_value = state.irq_enable_reg;
         end
      end
   end

endmodule

/* sv/banked_memory_map_decoder_unit.sv */
// Banked memory map decoder: one bus access in, one decoded word out
// Requests pass the input register, then the result register, to the response.
// One word per cycle when not stalled; decode and register update sit in one stage.
// The pipeline moves whenever the result register is empty or being taken.
// Reset (synchronous, active high) clears both valid flags, sets ROM bank 1,
// ROM banking mode, WRAM bank 1, boot overlay on; other bank registers zero.
`timescale 1ns / 1ps

module banked_memory_map_decoder_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  bmmd_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output bmmd_pkg::rsp_word_type rsp_word,
   input  logic                   csr_write_enable,
   input  logic                   csr_write_data
);
   import bmmd_pkg::*;

`include "banked_memory_map_decoder_unit_assert.svh"

   logic           in_valid_ff;
   logic           in_valid_in;
   req_word_type   in_word_ff;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   rsp_word_type   rsp_word_ff;
   rsp_word_type   dec_word;
   logic           boot_overlay_ff;
   logic           advance;
   bank_state_type bank_state;
   bank_state_type bank_state_next;

   // Advance the input word when the result register is free or draining
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && rsp_valid_ff && rsp_stall;

   // Boot overlay control register
   always_ff @(posedge clock) begin
      if (reset) begin
         boot_overlay_ff <= 1'b1;
      end else if (csr_write_enable) begin
         boot_overlay_ff <= csr_write_data;
      end
   end

   // Input register
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_word_ff <= req_word;
      end
   end

   // Decode against the current bank state
   bmmd_decode u_decode (
      .req          (in_word_ff),
      .state        (bank_state),
      .boot_overlay (boot_overlay_ff),
      .rsp          (dec_word),
      .state_next   (bank_state_next)
   );

   bmmd_bank_regs u_bank_regs (
      .clock    (clock),
      .reset    (reset),
      .update   (advance),
      .state_in (bank_state_next),
      .state    (bank_state)
   );

   // Result register; hold while stalled, drop once taken
   assign rsp_valid_in = advance ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_word_ff <= dec_word;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // Checks on the decode and the state update
   `BMMD_ASSERT_NXT(a_state_holds, clock, reset, !advance, $stable(bank_state))
   `BMMD_ASSERT_IMP(a_read_value_ie_only, clock, reset,
      rsp_valid && rsp_word.target != TGT_IE, rsp_word.read_value == '0)
   `BMMD_ASSERT_IMP(a_no_strobe_rom_side, clock, reset,
      rsp_valid && rsp_word.write_strobe,
      rsp_word.target != TGT_BOOT && rsp_word.target != TGT_ROM &&
      rsp_word.target != TGT_EXT_RAM && rsp_word.target != TGT_BANK_CTRL)
   `BMMD_ASSERT_IMP(a_ext_ram_zero, clock, reset,
      rsp_valid && rsp_word.target == TGT_EXT_RAM, rsp_word.offset == '0)

endmodule
